// File: sv/euler_attitude_compose_macros.svh
// ----------------------------------------------------------------------------
// Euler attitude composer assertion macros
// Shared concurrent assertion forms. Each one expects clk and rst_n in scope.
// ----------------------------------------------------------------------------
`ifndef EULER_ATTITUDE_COMPOSE_MACROS_SVH
`define EULER_ATTITUDE_COMPOSE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define EAC_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define EAC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: sv/eac_pkg.sv
// ----------------------------------------------------------------------------
// Euler attitude composer package
// Shared fixed-point types, mode codes, saturating multiply and the
// elaboration-time builders for the CORDIC arctangent table and gain.
// ----------------------------------------------------------------------------
package eac_pkg;

    localparam int QW = 32;
    localparam int AT_IW = 34;
    localparam logic [63:0] INV_TWO_PI_Q64 = 64'h28BE_60DB_9391_054A;

    typedef logic signed [QW-1:0] q_t;
    typedef q_t mat_t [9];
    typedef logic signed [AT_IW-1:0] at_in_t;

    typedef enum logic [1:0] {
        MODE_REL  = 2'd0,
        MODE_PLAT = 2'd1,
        MODE_TGT  = 2'd2,
        MODE_NONE = 2'd3
    } mode_t;

    function automatic q_t eac_sat(input logic signed [65:0] v);
        if (v > 66'sh4000_0000) begin
            return 32'sh4000_0000;
        end
        if (v < -66'sh4000_0000) begin
            return -32'sh4000_0000;
        end
        return q_t'(v);
    endfunction

    function automatic q_t eac_round(input logic signed [65:0] acc);
        logic signed [65:0] rnd;
        rnd = (acc + 66'sh2000_0000) >>> 30;
        return eac_sat(rnd);
    endfunction

    function automatic q_t eac_mulq(input q_t a, input q_t b);
        logic signed [63:0] prod;
        prod = a * b;
        return eac_round(66'(prod));
    endfunction

    function automatic logic [63:0] eac_udiv(input logic [63:0] n, input logic [63:0] d);
        logic [64:0] r;
        logic [63:0] q;
        r = '0;
        q = '0;
        for (int b = 63; b >= 0; b--) begin
            r = {r[63:0], n[b]};
            if (r >= {1'b0, d}) begin
                r = r - {1'b0, d};
                q[b] = 1'b1;
            end
        end
        return q;
    endfunction

    function automatic logic [63:0] eac_isqrt(input logic [63:0] v_in);
        logic [63:0] v;
        logic [63:0] r;
        logic [63:0] bt;
        v = v_in;
        r = '0;
        bt = 64'd1 << 62;
        for (int j = 0; j < 32; j++) begin
            if (bt > v) begin
                bt = bt >> 2;
            end
        end
        for (int j = 0; j < 32; j++) begin
            if (bt != 64'd0) begin
                if (v >= r + bt) begin
                    v = v - (r + bt);
                    r = (r >> 1) + bt;
                end else begin
                    r = r >> 1;
                end
                bt = bt >> 2;
            end
        end
        return r;
    endfunction

    function automatic logic [63:0] eac_atan_turns(input int i);
        logic [63:0] s;
        logic [63:0] t;
        logic [127:0] prod;
        int sh;
        if (i == 0) begin
            return 64'd1 << 61;
        end
        s = '0;
        for (int k = 0; k < 32; k++) begin
            sh = i * (2 * k + 1);
            if (sh <= 62) begin
                t = eac_udiv(64'd1 << (62 - sh), 64'(2 * k + 1));
                if (k[0]) begin
                    s = s - t;
                end else begin
                    s = s + t;
                end
            end
        end
        prod = {64'd0, s} * {64'd0, INV_TWO_PI_Q64};
        return prod[125:62];
    endfunction

    function automatic logic [63:0] eac_atan_entry(input int i, input int abits);
        logic [63:0] turns;
        turns = eac_atan_turns(i);
        return (turns + (64'd1 << (63 - abits))) >> (64 - abits);
    endfunction

    function automatic logic [63:0] eac_gain(input int iters);
        logic [63:0] v;
        v = 64'd1 << 62;
        for (int i = 0; i < 64; i++) begin
            if (i < iters) begin
                if (i == 0) begin
                    v = v >> 1;
                end else if (2 * i < 62) begin
                    v = v - eac_udiv(v, (64'd1 << (2 * i)) + 64'd1);
                end
            end
        end
        return (eac_isqrt(v) + 64'd1) >> 1;
    endfunction

endpackage

// File: sv/euler_attitude_compose.sv
// ----------------------------------------------------------------------------
// Euler attitude composer
// Composes two roll/pitch/heading attitudes and returns the composed
// attitude, or zero in mode NONE and in mode REL with an all-zero second
// attitude. The block is fully pipelined and takes one transfer per cycle
// while the output is not stalled. It is built from four CORDIC passes in
// series, each one register stage per iteration plus an entry and an exit
// stage: sine and cosine of the inputs, atan2 for heading, sine and cosine
// of the heading, and atan2 for pitch and roll, with the rotation-matrix,
// matrix-product and heading-multiply stages between. When the output
// register holds a result that is not taken, the whole pipeline holds.
// ----------------------------------------------------------------------------
`include "euler_attitude_compose_macros.svh"

module euler_attitude_compose #(
    parameter int ANGLE_BITS        = 32,
    parameter int CORDIC_ITERATIONS = 24
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [1:0]         mode,
    input  logic signed [31:0] first_roll,
    input  logic signed [31:0] first_pitch,
    input  logic signed [31:0] first_heading,
    input  logic signed [31:0] second_roll,
    input  logic signed [31:0] second_pitch,
    input  logic signed [31:0] second_heading,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [31:0] out_roll,
    output logic signed [31:0] out_pitch,
    output logic signed [31:0] out_heading
);

    import eac_pkg::*;

    localparam int NI  = CORDIC_ITERATIONS;
    localparam int ZW  = ANGLE_BITS + 1;
    localparam int LAT = 4 * NI + 16;
    localparam int UP_IN = (ANGLE_BITS > 32) ? ANGLE_BITS - 32 : 0;
    localparam int DN_IN = (ANGLE_BITS < 32) ? 32 - ANGLE_BITS : 0;
    localparam int DN_OUT = UP_IN;
    localparam int UP_OUT = DN_IN;
    localparam logic [ZW-1:0] RND_OUT = (DN_OUT > 0) ? (ZW'(1) << (DN_OUT - 1)) : '0;

    function automatic logic [ANGLE_BITS-1:0] to_phase(input logic [31:0] a);
        return ANGLE_BITS'((64'(a) << UP_IN) >> DN_IN);
    endfunction

    function automatic logic [31:0] to_out(input logic [ANGLE_BITS-1:0] ph);
        logic [ZW-1:0] ext;
        ext = {1'b0, ph} + RND_OUT;
        return 32'((64'(ext >> DN_OUT)) << UP_OUT);
    endfunction

    logic                  en;
    logic                  accept;
    logic                  kill;
    logic [LAT-1:0]        vld_reg;
    logic [ANGLE_BITS-1:0] ang_phase [6];
    q_t                    sin_a [6];
    q_t                    cos_a [6];
    mat_t                  f_mat;
    mat_t                  s_mat;
    mat_t                  p_mat;
    logic [1:0]            mode_d;
    logic                  kill_d;
    logic [ZW-1:0]         head_z;
    logic [ZW-1:0]         head_zd;
    logic [ZW-1:0]         pitch_z;
    logic [ZW-1:0]         roll_z;
    logic [7*QW-1:0]       p_pack;
    logic [7*QW-1:0]       p_packd;
    q_t                    pd00, pd01, pd02, pd10, pd11, pd12, pd20;
    q_t                    sin_h;
    q_t                    cos_h;
    q_t                    ma_reg, mb_reg, mc_reg, md_reg, me_reg, mf_reg;
    at_in_t                ny_reg;
    at_in_t                px_reg, py_reg, ry_reg, rx_reg;
    logic [31:0]           out_roll_reg, out_pitch_reg, out_heading_reg;
    logic [31:0]           out_roll_next, out_pitch_next, out_heading_next;
    logic                  kill_out_reg;

    assign en       = !vld_reg[LAT-1] || out_ready;
    assign in_ready = en;
    assign accept   = in_valid && in_ready;
    assign kill     = (mode_t'(mode) == MODE_NONE) ||
                      ((mode_t'(mode) == MODE_REL) && (second_roll == '0) &&
                       (second_pitch == '0) && (second_heading == '0));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[LAT-2:0], accept};
        end
    end

    assign ang_phase[0] = to_phase(first_roll);
    assign ang_phase[1] = to_phase(first_pitch);
    assign ang_phase[2] = to_phase(first_heading);
    assign ang_phase[3] = to_phase(second_roll);
    assign ang_phase[4] = to_phase(second_pitch);
    assign ang_phase[5] = to_phase(second_heading);

    for (genvar g = 0; g < 6; g++)
    begin : g_sc
        eac_sincos #(
            .ANGLE_BITS        (ANGLE_BITS),
            .CORDIC_ITERATIONS (CORDIC_ITERATIONS)
        ) u_sc (
            .clk     (clk),
            .en      (en),
            .phase   (ang_phase[g]),
            .sin_val (sin_a[g]),
            .cos_val (cos_a[g])
        );
    end

    eac_rotm u_rot_f (
        .clk (clk), .en (en),
        .sr (sin_a[0]), .cr (cos_a[0]),
        .sp (sin_a[1]), .cp (cos_a[1]),
        .sh (sin_a[2]), .ch (cos_a[2]),
        .m  (f_mat)
    );

    eac_rotm u_rot_s (
        .clk (clk), .en (en),
        .sr (sin_a[3]), .cr (cos_a[3]),
        .sp (sin_a[4]), .cp (cos_a[4]),
        .sh (sin_a[5]), .ch (cos_a[5]),
        .m  (s_mat)
    );

    eac_delay #(.WIDTH(2), .DEPTH(NI + 5)) u_mode_dly (
        .clk (clk), .en (en), .din (mode), .dout (mode_d)
    );

    eac_matmul u_mm (
        .clk  (clk),
        .en   (en),
        .mode (mode_d),
        .f    (f_mat),
        .s    (s_mat),
        .p    (p_mat)
    );

    eac_atan2 #(
        .ANGLE_BITS        (ANGLE_BITS),
        .CORDIC_ITERATIONS (CORDIC_ITERATIONS)
    ) u_at_head (
        .clk   (clk),
        .en    (en),
        .y_in  (AT_IW'(p_mat[3])),
        .x_in  (AT_IW'(p_mat[0])),
        .angle (head_z)
    );

    eac_sincos #(
        .ANGLE_BITS        (ANGLE_BITS),
        .CORDIC_ITERATIONS (CORDIC_ITERATIONS)
    ) u_sc_head (
        .clk     (clk),
        .en      (en),
        .phase   (head_z[ANGLE_BITS-1:0]),
        .sin_val (sin_h),
        .cos_val (cos_h)
    );

    assign p_pack = {p_mat[0], p_mat[1], p_mat[2], p_mat[3], p_mat[4], p_mat[5], p_mat[6]};

    eac_delay #(.WIDTH(7 * QW), .DEPTH(2 * NI + 4)) u_p_dly (
        .clk (clk), .en (en), .din (p_pack), .dout (p_packd)
    );

    assign {pd00, pd01, pd02, pd10, pd11, pd12, pd20} = p_packd;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ma_reg <= eac_mulq(pd00, cos_h);
            mb_reg <= eac_mulq(pd10, sin_h);
            mc_reg <= eac_mulq(pd02, sin_h);
            md_reg <= eac_mulq(pd12, cos_h);
            me_reg <= eac_mulq(pd11, cos_h);
            mf_reg <= eac_mulq(pd01, sin_h);
            ny_reg <= -AT_IW'(pd20);

            px_reg <= AT_IW'(ma_reg) + AT_IW'(mb_reg);
            py_reg <= ny_reg;
            ry_reg <= AT_IW'(mc_reg) - AT_IW'(md_reg);
            rx_reg <= AT_IW'(me_reg) - AT_IW'(mf_reg);
        end
    end

    eac_atan2 #(
        .ANGLE_BITS        (ANGLE_BITS),
        .CORDIC_ITERATIONS (CORDIC_ITERATIONS)
    ) u_at_pitch (
        .clk   (clk),
        .en    (en),
        .y_in  (py_reg),
        .x_in  (px_reg),
        .angle (pitch_z)
    );

    eac_atan2 #(
        .ANGLE_BITS        (ANGLE_BITS),
        .CORDIC_ITERATIONS (CORDIC_ITERATIONS)
    ) u_at_roll (
        .clk   (clk),
        .en    (en),
        .y_in  (ry_reg),
        .x_in  (rx_reg),
        .angle (roll_z)
    );

    eac_delay #(.WIDTH(ZW), .DEPTH(2 * NI + 6)) u_head_dly (
        .clk (clk), .en (en), .din (head_z), .dout (head_zd)
    );

    eac_delay #(.WIDTH(1), .DEPTH(LAT - 1)) u_kill_dly (
        .clk (clk), .en (en), .din (kill), .dout (kill_d)
    );

    always_comb
    begin
        out_roll_next    = kill_d ? '0 : to_out(roll_z[ANGLE_BITS-1:0]);
        out_pitch_next   = kill_d ? '0 : to_out(pitch_z[ANGLE_BITS-1:0]);
        out_heading_next = kill_d ? '0 : to_out(head_zd[ANGLE_BITS-1:0]);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_roll_reg    <= out_roll_next;
            out_pitch_reg   <= out_pitch_next;
            out_heading_reg <= out_heading_next;
            kill_out_reg    <= kill_d;
        end
    end

    assign out_valid   = vld_reg[LAT-1];
    assign out_roll    = out_roll_reg;
    assign out_pitch   = out_pitch_reg;
    assign out_heading = out_heading_reg;

    `EAC_ASSERT_NEXT(a_entry_valid, in_valid && in_ready, vld_reg[0], "accepted item did not enter the pipeline")
    `EAC_ASSERT_NEXT(a_entry_bubble, en && !in_valid, !vld_reg[0], "bubble entered as a valid item")
    `EAC_ASSERT_NEXT(a_stall_hold, !en, $stable(vld_reg) && $stable(out_roll_reg), "pipeline moved during a stall")
    `EAC_ASSERT_SAME(a_kill_zero, out_valid && kill_out_reg, (out_roll == '0) && (out_pitch == '0) && (out_heading == '0), "suppressed result is not zero")

endmodule

// File: sv/eac_delay.sv
// ----------------------------------------------------------------------------
// Euler attitude composer delay line
// Shift register that keeps side data aligned with the pipeline stages.
// ----------------------------------------------------------------------------
module eac_delay #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             en,
    input  logic [WIDTH-1:0] din,
    output logic [WIDTH-1:0] dout
);

    logic [WIDTH-1:0] tap_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            tap_reg[0] <= din;
            for (int k = 1; k < DEPTH; k++)
            begin
                tap_reg[k] <= tap_reg[k-1];
            end
        end
    end

    assign dout = tap_reg[DEPTH-1];

endmodule

// File: sv/eac_sincos.sv
// ----------------------------------------------------------------------------
// Euler attitude composer sine and cosine
// Pipelined rotation-mode CORDIC, one stage per iteration, Q1.30 outputs.
// ----------------------------------------------------------------------------
module eac_sincos #(
    parameter int ANGLE_BITS        = 32,
    parameter int CORDIC_ITERATIONS = 24
) (
    input  logic                  clk,
    input  logic                  en,
    input  logic [ANGLE_BITS-1:0] phase,
    output eac_pkg::q_t           sin_val,
    output eac_pkg::q_t           cos_val
);

    import eac_pkg::*;

    localparam int ZW  = ANGLE_BITS + 1;
    localparam int XYW = 34;
    localparam int NI  = CORDIC_ITERATIONS;
    localparam logic signed [ZW-1:0] QUARTER = {3'b001, {(ANGLE_BITS-2){1'b0}}};
    localparam logic signed [ZW-1:0] HALF    = {2'b01, {(ANGLE_BITS-1){1'b0}}};
    localparam logic [63:0] GAIN = eac_gain(CORDIC_ITERATIONS);

    logic signed [XYW-1:0] x_reg [NI+1];
    logic signed [XYW-1:0] y_reg [NI+1];
    logic signed [ZW-1:0]  z_reg [NI+1];
    logic                  neg_reg [NI+1];
    logic signed [ZW-1:0]  z_in;
    logic signed [ZW-1:0]  z_next;
    logic                  neg_next;
    q_t                    sin_reg;
    q_t                    cos_reg;
    q_t                    xs;
    q_t                    ys;

    always_comb
    begin
        z_in     = ZW'($signed(phase));
        z_next   = z_in;
        neg_next = 1'b0;
        if (z_in > QUARTER)
        begin
            z_next   = z_in - HALF;
            neg_next = 1'b1;
        end
        else if (z_in < -QUARTER)
        begin
            z_next   = z_in + HALF;
            neg_next = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg[0]   <= XYW'(GAIN);
            y_reg[0]   <= '0;
            z_reg[0]   <= z_next;
            neg_reg[0] <= neg_next;
        end
    end

    for (genvar i = 0; i < NI; i++)
    begin : g_iter
        localparam logic [63:0] ATAN_I = eac_atan_entry(i, ANGLE_BITS);
        localparam logic signed [ZW-1:0] ATAN_Z = ZW'(ATAN_I);

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                neg_reg[i+1] <= neg_reg[i];
                if (!z_reg[i][ZW-1])
                begin
                    x_reg[i+1] <= x_reg[i] - (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] + (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] - ATAN_Z;
                end
                else
                begin
                    x_reg[i+1] <= x_reg[i] + (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] - (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] + ATAN_Z;
                end
            end
        end
    end

    assign xs = eac_sat(66'(x_reg[NI]));
    assign ys = eac_sat(66'(y_reg[NI]));

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cos_reg <= neg_reg[NI] ? -xs : xs;
            sin_reg <= neg_reg[NI] ? -ys : ys;
        end
    end

    assign sin_val = sin_reg;
    assign cos_val = cos_reg;

endmodule

// File: sv/eac_atan2.sv
// ----------------------------------------------------------------------------
// Euler attitude composer arctangent
// Pipelined vectoring-mode CORDIC giving atan2(y, x) as a binary angle.
// ----------------------------------------------------------------------------
module eac_atan2 #(
    parameter int ANGLE_BITS        = 32,
    parameter int CORDIC_ITERATIONS = 24
) (
    input  logic                  clk,
    input  logic                  en,
    input  eac_pkg::at_in_t       y_in,
    input  eac_pkg::at_in_t       x_in,
    output logic [ANGLE_BITS:0]   angle
);

    import eac_pkg::*;

    localparam int ZW = ANGLE_BITS + 1;
    localparam int W  = AT_IW + 4;
    localparam int NI = CORDIC_ITERATIONS;
    localparam logic signed [ZW-1:0] QUARTER = {3'b001, {(ANGLE_BITS-2){1'b0}}};

    logic signed [W-1:0]  x_reg [NI+1];
    logic signed [W-1:0]  y_reg [NI+1];
    logic signed [ZW-1:0] z_reg [NI+1];
    logic                 zero_reg [NI+1];
    logic signed [W-1:0]  xw;
    logic signed [W-1:0]  yw;
    logic signed [W-1:0]  x_next;
    logic signed [W-1:0]  y_next;
    logic signed [ZW-1:0] z_next;
    logic [ZW-1:0]        angle_reg;

    always_comb
    begin
        xw     = W'(x_in);
        yw     = W'(y_in);
        x_next = xw;
        y_next = yw;
        z_next = '0;
        if (xw < 0)
        begin
            if (yw >= 0)
            begin
                x_next = yw;
                y_next = -xw;
                z_next = QUARTER;
            end
            else
            begin
                x_next = -yw;
                y_next = xw;
                z_next = -QUARTER;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg[0]    <= x_next;
            y_reg[0]    <= y_next;
            z_reg[0]    <= z_next;
            zero_reg[0] <= (xw == '0) && (yw == '0);
        end
    end

    for (genvar i = 0; i < NI; i++)
    begin : g_iter
        localparam logic [63:0] ATAN_I = eac_atan_entry(i, ANGLE_BITS);
        localparam logic signed [ZW-1:0] ATAN_Z = ZW'(ATAN_I);

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                zero_reg[i+1] <= zero_reg[i];
                if (!y_reg[i][W-1])
                begin
                    x_reg[i+1] <= x_reg[i] + (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] - (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] + ATAN_Z;
                end
                else
                begin
                    x_reg[i+1] <= x_reg[i] - (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] + (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] - ATAN_Z;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            angle_reg <= zero_reg[NI] ? '0 : z_reg[NI];
        end
    end

    assign angle = angle_reg;

endmodule

// File: sv/eac_rotm.sv
// ----------------------------------------------------------------------------
// Euler attitude composer rotation matrix
// Three-stage build of Rz(heading) * Ry(pitch) * Rx(roll) from sines and
// cosines, with rounded and saturated Q1.30 products.
// ----------------------------------------------------------------------------
module eac_rotm (
    input  logic          clk,
    input  logic          en,
    input  eac_pkg::q_t   sr,
    input  eac_pkg::q_t   cr,
    input  eac_pkg::q_t   sp,
    input  eac_pkg::q_t   cp,
    input  eac_pkg::q_t   sh,
    input  eac_pkg::q_t   ch,
    output eac_pkg::mat_t m
);

    import eac_pkg::*;

    q_t chcp_reg, shcp_reg, cpsr_reg, cpcr_reg, chsp_reg, shsp_reg;
    q_t nshcr_reg, shsr_reg, chcr_reg, nchsr_reg, nsp_reg, sr_reg, cr_reg;
    q_t chcp2_reg, shcp2_reg, cpsr2_reg, cpcr2_reg;
    q_t nshcr2_reg, shsr2_reg, chcr2_reg, nchsr2_reg, nsp2_reg;
    q_t chspsr_reg, chspcr_reg, shspsr_reg, shspcr_reg;
    q_t m_reg [9];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            chcp_reg  <= eac_mulq(ch, cp);
            shcp_reg  <= eac_mulq(sh, cp);
            cpsr_reg  <= eac_mulq(cp, sr);
            cpcr_reg  <= eac_mulq(cp, cr);
            chsp_reg  <= eac_mulq(ch, sp);
            shsp_reg  <= eac_mulq(sh, sp);
            nshcr_reg <= eac_mulq(-sh, cr);
            shsr_reg  <= eac_mulq(sh, sr);
            chcr_reg  <= eac_mulq(ch, cr);
            nchsr_reg <= eac_mulq(-ch, sr);
            nsp_reg   <= -sp;
            sr_reg    <= sr;
            cr_reg    <= cr;

            chspsr_reg <= eac_mulq(chsp_reg, sr_reg);
            chspcr_reg <= eac_mulq(chsp_reg, cr_reg);
            shspsr_reg <= eac_mulq(shsp_reg, sr_reg);
            shspcr_reg <= eac_mulq(shsp_reg, cr_reg);
            chcp2_reg  <= chcp_reg;
            shcp2_reg  <= shcp_reg;
            cpsr2_reg  <= cpsr_reg;
            cpcr2_reg  <= cpcr_reg;
            nshcr2_reg <= nshcr_reg;
            shsr2_reg  <= shsr_reg;
            chcr2_reg  <= chcr_reg;
            nchsr2_reg <= nchsr_reg;
            nsp2_reg   <= nsp_reg;

            m_reg[0] <= chcp2_reg;
            m_reg[1] <= eac_sat(66'(nshcr2_reg) + 66'(chspsr_reg));
            m_reg[2] <= eac_sat(66'(shsr2_reg) + 66'(chspcr_reg));
            m_reg[3] <= shcp2_reg;
            m_reg[4] <= eac_sat(66'(chcr2_reg) + 66'(shspsr_reg));
            m_reg[5] <= eac_sat(66'(nchsr2_reg) + 66'(shspcr_reg));
            m_reg[6] <= nsp2_reg;
            m_reg[7] <= cpsr2_reg;
            m_reg[8] <= cpcr2_reg;
        end
    end

    assign m = m_reg;

endmodule

// File: sv/eac_matmul.sv
// ----------------------------------------------------------------------------
// Euler attitude composer matrix product
// Two-stage 3x3 product with operand order and transposes chosen by mode:
// all 27 products in the first stage, sums and rounding in the second.
// ----------------------------------------------------------------------------
module eac_matmul (
    input  logic           clk,
    input  logic           en,
    input  logic [1:0]     mode,
    input  eac_pkg::mat_t  f,
    input  eac_pkg::mat_t  s,
    output eac_pkg::mat_t  p
);

    import eac_pkg::*;

    q_t                 op_a [9][3];
    q_t                 op_b [9][3];
    logic signed [63:0] prod_reg [9][3];
    q_t                 p_reg [9];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                for (int k = 0; k < 3; k++)
                begin
                    case (mode_t'(mode))
                        MODE_REL:
                        begin
                            op_a[i*3+j][k] = s[k*3+i];
                            op_b[i*3+j][k] = f[k*3+j];
                        end
                        MODE_PLAT:
                        begin
                            op_a[i*3+j][k] = f[i*3+k];
                            op_b[i*3+j][k] = s[j*3+k];
                        end
                        default:
                        begin
                            op_a[i*3+j][k] = f[i*3+k];
                            op_b[i*3+j][k] = s[k*3+j];
                        end
                    endcase
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int e = 0; e < 9; e++)
            begin
                for (int k = 0; k < 3; k++)
                begin
                    prod_reg[e][k] <= op_a[e][k] * op_b[e][k];
                end
                p_reg[e] <= eac_round(66'(prod_reg[e][0]) + 66'(prod_reg[e][1])
                                      + 66'(prod_reg[e][2]));
            end
        end
    end

    assign p = p_reg;

endmodule

// File: tb/testbench.sv
// ----------------------------------------------------------------------------
// Euler attitude composer testbench
// Drives attitude pairs in all modes through the valid/ready input, with
// random gaps and output stalls, and checks every composed attitude against
// a bit-exact fixed-point CORDIC model of the rotation composition.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import eac_pkg::*;

    localparam int N_STEPS = 24;
    localparam int N_RANDOM = 1250;
    localparam int IDLE_LIMIT = 4000;
    localparam int DRAIN_CYCLES = 150;
    localparam longint Q_ONE = 64'sd1 << 30;
    localparam longint QUARTER = 64'sd1 << 30;
    localparam longint HALF = 64'sd1 << 31;
    localparam logic signed [31:0] A_MIN = 32'sh8000_0000;
    localparam logic signed [31:0] A_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] A_QTR = 32'sh4000_0000;

    typedef struct packed {
        logic signed [31:0] roll;
        logic signed [31:0] pitch;
        logic signed [31:0] heading;
    } attitude_t;

    typedef struct {
        mode_t     op;
        attitude_t a;
        attitude_t b;
        logic      known;
        attitude_t res;
    } stim_row_t;

    typedef longint mat3_t [3][3];

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic [1:0] mode = '0;
    logic signed [31:0] first_roll = '0, first_pitch = '0, first_heading = '0;
    logic signed [31:0] second_roll = '0, second_pitch = '0, second_heading = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic signed [31:0] out_roll, out_pitch, out_heading;

    logic row_known = 1'b0;
    attitude_t row_res = '0;

    longint atan_step [N_STEPS];
    longint cordic_gain;
    attitude_t composed_q[$];
    int errors = 0;
    int idle_cycles = 0;
    bit no_gaps = 0;

    euler_attitude_compose dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .mode(mode),
        .first_roll(first_roll), .first_pitch(first_pitch), .first_heading(first_heading),
        .second_roll(second_roll), .second_pitch(second_pitch),
        .second_heading(second_heading),
        .out_valid(out_valid), .out_ready(out_ready),
        .out_roll(out_roll), .out_pitch(out_pitch), .out_heading(out_heading)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic void build_cordic_consts();
        logic [63:0] s, t, v, turns, r, bt;
        logic [127:0] prod;
        int sh;
        v = 64'd1 << 62;
        for (int i = 0; i < N_STEPS; i++)
        begin
            if (i == 0)
            begin
                turns = 64'd1 << 61;
            end
            else
            begin
                s = '0;
                for (int k = 0; k < 32; k++)
                begin
                    sh = i * (2 * k + 1);
                    if (sh <= 62)
                    begin
                        t = (64'd1 << (62 - sh)) / 64'(2 * k + 1);
                        if (k % 2 == 1) s = s - t;
                        else s = s + t;
                    end
                end
                prod = {64'd0, s} * {64'd0, 64'h28BE_60DB_9391_054A};
                turns = prod[125:62];
            end
            atan_step[i] = longint'((turns + 64'h8000_0000) >> 32);
            if (i == 0) v = v >> 1;
            else if (2 * i < 62) v = v - v / ((64'd1 << (2 * i)) + 64'd1);
        end
        r = '0;
        bt = 64'd1 << 62;
        while (bt > v) bt = bt >> 2;
        while (bt != 0)
        begin
            if (v >= r + bt)
            begin
                v = v - (r + bt);
                r = (r >> 1) + bt;
            end
            else
            begin
                r = r >> 1;
            end
            bt = bt >> 2;
        end
        cordic_gain = longint'((r + 64'd1) >> 1);
    endfunction

    function automatic longint clamp_q30(longint v);
        if (v > Q_ONE) return Q_ONE;
        if (v < -Q_ONE) return -Q_ONE;
        return v;
    endfunction

    function automatic longint round_q30(longint v);
        return clamp_q30((v + (64'sd1 << 29)) >>> 30);
    endfunction

    function automatic longint qmul(longint a, longint b);
        return round_q30(a * b);
    endfunction

    function automatic void phase_sin_cos(logic [31:0] ph, output longint sn, output longint cs);
        longint z, x, y, nx, ny;
        bit flip;
        z = longint'($signed(ph));
        x = cordic_gain;
        y = 0;
        flip = 0;
        if (z > QUARTER)
        begin
            z = z - HALF;
            flip = 1;
        end
        else if (z < -QUARTER)
        begin
            z = z + HALF;
            flip = 1;
        end
        for (int i = 0; i < N_STEPS; i++)
        begin
            if (z >= 0)
            begin
                nx = x - (y >>> i);
                ny = y + (x >>> i);
                z = z - atan_step[i];
            end
            else
            begin
                nx = x + (y >>> i);
                ny = y - (x >>> i);
                z = z + atan_step[i];
            end
            x = nx;
            y = ny;
        end
        x = clamp_q30(x);
        y = clamp_q30(y);
        cs = flip ? -x : x;
        sn = flip ? -y : y;
    endfunction

    function automatic longint vector_angle(longint y, longint x);
        longint z, t, nx, ny;
        z = 0;
        if (x == 0 && y == 0) return 0;
        if (x < 0)
        begin
            t = x;
            if (y >= 0)
            begin
                x = y;
                y = -t;
                z = QUARTER;
            end
            else
            begin
                x = -y;
                y = t;
                z = -QUARTER;
            end
        end
        for (int i = 0; i < N_STEPS; i++)
        begin
            if (y >= 0)
            begin
                nx = x + (y >>> i);
                ny = y - (x >>> i);
                z = z + atan_step[i];
            end
            else
            begin
                nx = x - (y >>> i);
                ny = y + (x >>> i);
                z = z - atan_step[i];
            end
            x = nx;
            y = ny;
        end
        return z;
    endfunction

    function automatic void rotation_of(attitude_t a, output mat3_t m);
        longint sr, cr, sp, cp, sh, ch;
        phase_sin_cos(a.roll, sr, cr);
        phase_sin_cos(a.pitch, sp, cp);
        phase_sin_cos(a.heading, sh, ch);
        m[0][0] = qmul(ch, cp);
        m[0][1] = clamp_q30(qmul(-sh, cr) + qmul(qmul(ch, sp), sr));
        m[0][2] = clamp_q30(qmul(sh, sr) + qmul(qmul(ch, sp), cr));
        m[1][0] = qmul(sh, cp);
        m[1][1] = clamp_q30(qmul(ch, cr) + qmul(qmul(sh, sp), sr));
        m[1][2] = clamp_q30(qmul(-ch, sr) + qmul(qmul(sh, sp), cr));
        m[2][0] = -sp;
        m[2][1] = qmul(cp, sr);
        m[2][2] = qmul(cp, cr);
    endfunction

    function automatic attitude_t compose_attitude(mode_t op, attitude_t a, attitude_t b);
        mat3_t f, s, p;
        longint acc, h, sh, ch, pz;
        attitude_t res;
        res = '0;
        if (op == MODE_NONE) return res;
        if (op == MODE_REL && b == '0) return res;
        rotation_of(a, f);
        rotation_of(b, s);
        for (int i = 0; i < 3; i++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                acc = 0;
                for (int k = 0; k < 3; k++)
                begin
                    if (op == MODE_REL) acc += s[k][i] * f[k][j];
                    else if (op == MODE_PLAT) acc += f[i][k] * s[j][k];
                    else acc += f[i][k] * s[k][j];
                end
                p[i][j] = round_q30(acc);
            end
        end
        h = vector_angle(p[1][0], p[0][0]);
        phase_sin_cos(h[31:0], sh, ch);
        res.heading = h[31:0];
        pz = vector_angle(-p[2][0], qmul(p[0][0], ch) + qmul(p[1][0], sh));
        res.pitch = pz[31:0];
        pz = vector_angle(qmul(p[0][2], sh) - qmul(p[1][2], ch),
                          qmul(p[1][1], ch) - qmul(p[0][1], sh));
        res.roll = pz[31:0];
        return res;
    endfunction

    always @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            if (row_known)
                composed_q.push_back(row_res);
            else
                composed_q.push_back(compose_attitude(mode_t'(mode),
                    '{first_roll, first_pitch, first_heading},
                    '{second_roll, second_pitch, second_heading}));
        end
    end

    always @(posedge clk)
    begin
        attitude_t want;
        if (out_valid && out_ready)
        begin
            if (composed_q.size() == 0)
            begin
                $display("%0t: unexpected transfer roll=%h pitch=%h heading=%h",
                         $time, out_roll, out_pitch, out_heading);
                errors++;
            end
            else
            begin
                want = composed_q.pop_front();
                if (out_roll !== want.roll)
                begin
                    $display("%0t: roll expected %h actual %h", $time, want.roll, out_roll);
                    errors++;
                end
                if (out_pitch !== want.pitch)
                begin
                    $display("%0t: pitch expected %h actual %h", $time, want.pitch, out_pitch);
                    errors++;
                end
                if (out_heading !== want.heading)
                begin
                    $display("%0t: heading expected %h actual %h",
                             $time, want.heading, out_heading);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    initial
    begin
        int stall;
        @(posedge rst_n);
        forever
        begin
            stall = no_gaps ? 0 : $urandom_range(0, 17);
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!out_valid) @(posedge clk);
        end
    end

    task automatic send_pair(mode_t op, attitude_t a, attitude_t b, logic known, attitude_t res);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 17);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        mode <= op;
        first_roll <= a.roll;
        first_pitch <= a.pitch;
        first_heading <= a.heading;
        second_roll <= b.roll;
        second_pitch <= b.pitch;
        second_heading <= b.heading;
        row_known <= known;
        row_res <= res;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
    endtask

    function automatic logic signed [31:0] pick_angle();
        case ($urandom_range(0, 9))
            0: return A_MIN;
            1: return A_MAX;
            2: return '0;
            3: return $urandom_range(0, 1) ? A_QTR : -A_QTR;
            4: return $signed(32'($urandom_range(0, 64))) - 32;
            default: return $urandom;
        endcase
    endfunction

    initial
    begin
        stim_row_t rows[$];
        attitude_t a, b, z;
        mode_t op;
        int pick;
        z = '0;
        build_cordic_consts();
        rows = '{
            '{MODE_REL,  '{A_MAX, A_MIN, 32'sd12345}, z, 1'b1, z},
            '{MODE_REL,  z, z, 1'b1, z},
            '{MODE_NONE, '{A_MAX, A_MAX, A_MAX}, '{A_MIN, A_MIN, A_MIN}, 1'b1, z},
            '{MODE_NONE, z, '{-32'sd1, -32'sd1, -32'sd1}, 1'b1, z},
            '{MODE_REL,  z, '{32'sd0, 32'sd0, 32'sd1}, 1'b0, z},
            '{MODE_PLAT, z, z, 1'b0, z},
            '{MODE_TGT,  z, z, 1'b0, z},
            '{MODE_REL,  '{A_MIN, A_MIN, A_MIN}, '{A_MAX, A_MAX, A_MAX}, 1'b0, z},
            '{MODE_PLAT, '{A_MAX, A_MAX, A_MAX}, '{A_MIN, A_MIN, A_MIN}, 1'b0, z},
            '{MODE_TGT,  '{A_MIN, A_MAX, A_MIN}, '{A_MAX, A_MIN, A_MAX}, 1'b0, z},
            '{MODE_TGT,  '{32'sd0, A_QTR, 32'sd0}, z, 1'b0, z},
            '{MODE_PLAT, '{32'sd7, -A_QTR, 32'sd9}, '{32'sd3, 32'sd0, -32'sd5}, 1'b0, z},
            '{MODE_REL,  '{A_QTR, A_QTR, A_QTR}, '{A_QTR, A_QTR, A_QTR}, 1'b0, z},
            '{MODE_TGT,  '{-A_QTR, 32'sd0, A_MIN}, '{A_QTR, A_QTR, 32'sd0}, 1'b0, z},
            '{MODE_PLAT, '{32'sh5555_5555, 32'sh2AAA_AAAA, -32'sh5555_5555},
                         '{-32'sh2AAA_AAAA, 32'sh1234_5678, 32'sh6000_0000}, 1'b0, z}
        };
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        foreach (rows[i])
            send_pair(rows[i].op, rows[i].a, rows[i].b, rows[i].known, rows[i].res);
        for (int n = 0; n < N_RANDOM; n++)
        begin
            if (n % 100 == 0)
                no_gaps = ($urandom_range(0, 3) == 0);
            if (n == N_RANDOM / 2)
            begin
                in_valid <= 1'b0;
                @(posedge clk);
                while (composed_q.size() != 0) @(posedge clk);
            end
            pick = $urandom_range(0, 19);
            op = (pick == 0) ? MODE_NONE : mode_t'(pick % 3);
            a = '{pick_angle(), pick_angle(), pick_angle()};
            b = '{pick_angle(), pick_angle(), pick_angle()};
            if ($urandom_range(0, 15) == 0) b = '0;
            send_pair(op, a, b, 1'b0, z);
        end
        in_valid <= 1'b0;
        @(posedge clk);
        while (composed_q.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end
endmodule
